// ----- rtl/arwc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arwc_pkg
// Shared sizes, verdict codes and controller command type for the
// anti-replay window checker.
// ----------------------------------------------------------------------------
package arwc_pkg;

  localparam int SOURCES     = 256;
  localparam int WIN_W       = 64;
  localparam int ID_W        = 8;
  localparam int NONCE_W     = 64;
  localparam int VERDICT_W   = 2;
  localparam int ADDR_W      = $clog2(SOURCES);
  localparam int SH_W        = $clog2(WIN_W);
  localparam int ENTRY_W     = NONCE_W + WIN_W;

  typedef enum logic [VERDICT_W-1:0] {
    VERDICT_FRESH      = 2'd0,
    VERDICT_BAD_SOURCE = 2'd1,
    VERDICT_TOO_OLD    = 2'd2,
    VERDICT_DUPLICATE  = 2'd3
  } verdict_t;

  // controller -> datapath commands
  typedef struct packed {
    logic load;  // capture request, launch entry read
    logic cmp;   // compare nonce against stored highest
    logic upd;   // decide, write entry back, load result register
  } arwc_cmd_t;

endpackage

// ----- rtl/arwc_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arwc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module arwc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- rtl/arwc_dpath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arwc_dpath
// Per-source entry store, nonce compare and window update datapath.
// ----------------------------------------------------------------------------
module arwc_dpath (
  input  logic                            clk,
  input  logic                            rst_n,
  input  arwc_pkg::arwc_cmd_t             cmd,
  input  logic [arwc_pkg::ID_W-1:0]       in_source_id,
  input  logic [arwc_pkg::NONCE_W-1:0]    in_nonce,
  output logic                            out_accepted,
  output logic [arwc_pkg::VERDICT_W-1:0]  out_verdict
);

  import arwc_pkg::*;

  // request registers
  logic [ID_W-1:0]        id_r;
  logic [NONCE_W-1:0]     nonce_r;
  // compare stage registers
  logic [NONCE_W-1:0]     hi_r;
  logic [WIN_W-1:0]       mask_r;
  logic                   higher_r;
  logic                   far_r;
  logic [SH_W-1:0]        shamt_r;
  // armed flags, cleared at reset
  logic [SOURCES-1:0]     armed_r;
  logic [SOURCES-1:0]     armed_nxt;
  // result register
  logic                   acc_r;
  verdict_t               verdict_r;

  logic [ENTRY_W-1:0]     rd_entry;
  logic [NONCE_W-1:0]     rd_hi;
  logic [WIN_W-1:0]       rd_mask;
  logic [NONCE_W-1:0]     gap;
  logic                   higher;

  logic [ADDR_W-1:0]      addr;
  logic                   bad_src;
  logic                   armed;
  logic                   wr_en;
  logic [NONCE_W-1:0]     wr_hi;
  logic [WIN_W-1:0]       wr_mask;
  verdict_t               verdict;

  function automatic logic in_nonce_gt(input logic [NONCE_W-1:0] a,
                                       input logic [NONCE_W-1:0] b);
    return a > b;
  endfunction

  assign rd_hi   = rd_entry[ENTRY_W-1 -: NONCE_W];
  assign rd_mask = rd_entry[WIN_W-1:0];

  arwc_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (SOURCES)
  ) u_entry_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (addr),
    .wr_data ({wr_hi, wr_mask}),
    .rd_en   (cmd.load),
    .rd_addr (ADDR_W'(in_source_id)),
    .rd_data (rd_entry)
  );

  // compare: distance from the stored highest nonce, either direction
  always_comb begin
    higher = in_nonce_gt(nonce_r, rd_hi);
    gap    = higher ? (nonce_r - rd_hi) : (rd_hi - nonce_r);
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      id_r    <= in_source_id;
      nonce_r <= in_nonce;
    end
    if (cmd.cmp) begin
      hi_r     <= rd_hi;
      mask_r   <= rd_mask;
      higher_r <= higher;
      far_r    <= (gap >= NONCE_W'(WIN_W));
      shamt_r  <= gap[SH_W-1:0];
    end
  end

  // update: verdict and write-back
  assign addr    = ADDR_W'(id_r);
  assign bad_src = (id_r == '0) || (32'(id_r) >= SOURCES);
  assign armed   = armed_r[addr];

  always_comb begin
    wr_en     = 1'b0;
    wr_hi     = hi_r;
    wr_mask   = mask_r;
    verdict   = VERDICT_FRESH;
    armed_nxt = armed_r;
    if (bad_src) begin
      verdict = VERDICT_BAD_SOURCE;
    end else if (!armed) begin
      wr_en           = cmd.upd;
      wr_hi           = nonce_r;
      wr_mask         = WIN_W'(1);
      armed_nxt[addr] = 1'b1;
    end else if (higher_r) begin
      wr_en   = cmd.upd;
      wr_hi   = nonce_r;
      wr_mask = (far_r ? '0 : (mask_r << shamt_r)) | WIN_W'(1);
    end else if (far_r) begin
      verdict = VERDICT_TOO_OLD;
    end else if (mask_r[shamt_r]) begin
      verdict = VERDICT_DUPLICATE;
    end else begin
      wr_en   = cmd.upd;
      wr_mask = mask_r | (WIN_W'(1) << shamt_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      armed_r <= '0;
    end else if (cmd.upd) begin
      armed_r <= armed_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.upd) begin
      acc_r     <= (verdict == VERDICT_FRESH);
      verdict_r <= verdict;
    end
  end

  assign out_accepted = acc_r;
  assign out_verdict  = verdict_r;

endmodule

// ----- rtl/arwc_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arwc_ctrl
// Request sequencer: accept, compare, update, and result valid tracking.
// ----------------------------------------------------------------------------
module arwc_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  output logic                out_valid,
  input  logic                out_stall,
  output arwc_pkg::arwc_cmd_t cmd
);

  import arwc_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_CMP  = 3'b010,
    ST_UPD  = 3'b100
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   in_take;
  logic   upd_go;

  assign in_stall = (state_r != ST_IDLE);
  assign in_take  = in_valid && !in_stall;
  // result register must be free (or draining this cycle)
  assign upd_go   = (state_r == ST_UPD) && (!out_valid_r || !out_stall);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_take) state_nxt = ST_CMP;
      ST_CMP:  state_nxt = ST_UPD;
      ST_UPD:  if (upd_go) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (upd_go) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign cmd.load  = in_take;
  assign cmd.cmp   = (state_r == ST_CMP);
  assign cmd.upd   = upd_go;
  assign out_valid = out_valid_r;

  a_take_to_cmp: assert property (@(posedge clk) disable iff (!rst_n)
    in_take |=> state_r == ST_CMP)
    else $error("accepted request did not move to compare");

  a_cmp_to_upd: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_CMP |=> state_r == ST_UPD)
    else $error("compare did not advance to update");

  a_upd_result: assert property (@(posedge clk) disable iff (!rst_n)
    upd_go |=> out_valid_r && state_r == ST_IDLE)
    else $error("update did not present a result");

endmodule

// ----- rtl/anti_replay_window_check_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// anti_replay_window_check_top
// Sliding-window anti-replay check over 64-bit nonces, one entry per source.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel  in_valid / in_stall carries a request: in_source_id and
//   in_nonce. A request is taken on a clock edge with in_valid high and
//   in_stall low.
//   Result channel out_valid / out_stall carries out_accepted and
//   out_verdict (fresh, bad source, too old, duplicate), one per request,
//   in request order.
// Sequence:
//   A request passes through entry RAM read, 64-bit compare, then the
//   window update and write-back, which also loads the result register.
//   The sequencer steps through these in order, so a new request is
//   taken only after the previous one has finished its update.
//   in_stall is low only while the sequencer is idle; it can take the
//   next request while the previous result still waits in the result
//   register.
// Stall / reset:
//   If out_stall holds the result register full, the update step waits
//   and in_stall stays high. Reset (rst_n low, synchronous) clears all
//   armed flags and the result valid; the entry RAM needs no clearing,
//   since the stored entry of an unarmed source is never used.
// ----------------------------------------------------------------------------
module anti_replay_window_check_top (
  input  logic                            clk,
  input  logic                            rst_n,
  // request channel
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [arwc_pkg::ID_W-1:0]       in_source_id,
  input  logic [arwc_pkg::NONCE_W-1:0]    in_nonce,
  // result channel
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            out_accepted,
  output logic [arwc_pkg::VERDICT_W-1:0]  out_verdict
);

  import arwc_pkg::*;

  arwc_cmd_t cmd;

  // sequencer: owns handshakes and steps the datapath
  arwc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  // datapath: entry RAM, armed flags, compare and window update
  arwc_dpath u_dpath (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .in_source_id (in_source_id),
    .in_nonce     (in_nonce),
    .out_accepted (out_accepted),
    .out_verdict  (out_verdict)
  );

endmodule
